@@ rtl/assert_macros.svh @@
// Assertion macros used by the searchable deque top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SDQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDQ_ASSERT(lbl, clk, rst, prop, msg)
`define SDQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/sdq_pkg.sv @@
// Types and constants for the searchable deque.
`timescale 1ns / 1ps
package sdq_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int DATA_W_DEF = 32;
  localparam int REQ_W      = 3;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ_AT    = 3'd4,
    REQ_SEARCH     = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_up;    // push front: every cell takes its lower neighbor
    logic shift_down;  // pop front: every cell takes its upper neighbor
    logic wr_back;     // push back: the cell at the fill index takes the new word
    logic scan_clr;    // clear the lookup chain
    logic scan_en;     // advance the lookup chain one cell
    logic is_read;     // lookup matches by index rather than by value
  } cell_ctrl_t;

endpackage

@@ rtl/sdq_cell.sv @@
// One storage cell of the deque chain with its slice of the lookup chain.
`timescale 1ns / 1ps
module sdq_cell #(
  parameter int DATA_WIDTH = sdq_pkg::DATA_W_DEF,
  parameter int FILL_W     = 7,
  parameter int INDEX      = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sdq_pkg::cell_ctrl_t      ctrl,
  input  logic [FILL_W-1:0]        fill,
  input  logic [DATA_WIDTH-1:0]    key,
  input  logic [sdq_pkg::POS_W-1:0] pos,
  input  logic [DATA_WIDTH-1:0]    new_word,
  input  logic [DATA_WIDTH-1:0]    prev_word,
  input  logic [DATA_WIDTH-1:0]    next_word,
  input  logic                     scan_hit_in,
  input  logic [DATA_WIDTH-1:0]    scan_data_in,
  output logic [DATA_WIDTH-1:0]    word,
  output logic                     scan_hit,
  output logic [DATA_WIDTH-1:0]    scan_data
);

  localparam logic [FILL_W-1:0]           IDX_F = FILL_W'(INDEX);
  localparam logic [sdq_pkg::POS_W:0]     IDX_P = (sdq_pkg::POS_W + 1)'(INDEX);

  logic in_use;
  logic match;
  logic local_hit;

  assign in_use    = IDX_F < fill;
  assign match     = ctrl.is_read ? ({1'b0, pos} == IDX_P) : (word == key);
  assign local_hit = in_use && match;

  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      word <= prev_word;
    end else if (ctrl.shift_down) begin
      word <= next_word;
    end else if (ctrl.wr_back && (fill == IDX_F)) begin
      word <= new_word;
    end
  end

  // Pass the first hit toward the end of the chain.
  always_ff @(posedge clk) begin
    if (rst || ctrl.scan_clr) begin
      scan_hit <= 1'b0;
    end else if (ctrl.scan_en) begin
      scan_hit <= scan_hit_in || local_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_en) begin
      scan_data <= scan_hit_in ? scan_data_in : word;
    end
  end

endmodule

@@ rtl/searchable_deque_unit.sv @@
// Top level of the searchable deque: request decode, fill count and cell chain.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A bounded double-ended queue of DEPTH words of DATA_WIDTH bits, kept in a
// row of cells where cell i always holds the element at position i from the
// front. Push front shifts the whole row up by one cell, pop front shifts it
// down, push back writes the cell at the fill index and pop back only lowers
// the count. Each request answers with one beat: ok, data and the count after
// the request. For pushes, pops and unused request codes the result is
// registered at the accepting edge and the next request may enter at the
// following edge. For read at and search, after the accepting edge a hit
// token runs through the lookup chain one cell per cycle, and once the
// output is free the result register is loaded. The chain length sets how
// long a lookup runs. One request is in flight at a time; a new request
// is taken while a finished result still waits only if that result is taken
// in the same cycle. Stored words are the low DATA_WIDTH bits of value; data
// returns the stored word zero-extended or truncated to 32 bits. Cells hold
// no reset value; only positions below the count are ever looked at.
module searchable_deque_unit #(
  parameter int DEPTH      = sdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sdq_pkg::DATA_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic [sdq_pkg::REQ_W-1:0]        req_type,
  input  logic signed [sdq_pkg::VALUE_W-1:0] value,
  input  logic [sdq_pkg::POS_W-1:0]        position,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output logic                             ok,
  output logic signed [sdq_pkg::VALUE_W-1:0] data,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SCAN_W = $clog2(DEPTH);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(DEPTH);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(DEPTH - 1);

  sdq_pkg::state_t     state, state_next;
  sdq_pkg::cell_ctrl_t ctrl;

  logic [FILL_W-1:0]         fill, fill_next;
  logic [SCAN_W-1:0]         scan_cnt, scan_cnt_next;
  logic                      read_q;
  logic [DATA_WIDTH-1:0]     key;
  logic [sdq_pkg::POS_W-1:0] pos_q;
  logic [DATA_WIDTH-1:0]     new_word;

  logic req_fire;
  logic out_free;
  logic load_rsp;
  logic ok_next;
  logic [sdq_pkg::VALUE_W-1:0] data_next;

  logic [DATA_WIDTH-1:0] words     [DEPTH];
  logic                  hits      [DEPTH];
  logic [DATA_WIDTH-1:0] hit_words [DEPTH];

  // Stored words are the low DATA_WIDTH bits of the request value.
  assign new_word  = DATA_WIDTH'($unsigned(value));
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == sdq_pkg::S_IDLE) && out_free;
  assign req_fire  = req_valid && req_ready;
  assign count     = fill;

  // Decode the request, step the lookup chain, build the result beat.
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    scan_cnt_next = scan_cnt;
    ctrl          = '0;
    ctrl.is_read  = read_q;
    load_rsp      = 1'b0;
    ok_next       = 1'b0;
    data_next     = '0;
    unique case (state)
      sdq_pkg::S_IDLE: begin
        if (req_fire) begin
          ctrl.scan_clr = 1'b1;
          scan_cnt_next = '0;
          unique case (sdq_pkg::req_t'(req_type)) inside
            sdq_pkg::REQ_PUSH_FRONT: begin
              load_rsp = 1'b1;
              if (fill != FULL) begin
                ctrl.shift_up = 1'b1;
                fill_next     = fill + 1'b1;
                ok_next       = 1'b1;
              end
            end
            sdq_pkg::REQ_PUSH_BACK: begin
              load_rsp = 1'b1;
              if (fill != FULL) begin
                ctrl.wr_back = 1'b1;
                fill_next    = fill + 1'b1;
                ok_next      = 1'b1;
              end
            end
            sdq_pkg::REQ_POP_FRONT: begin
              load_rsp = 1'b1;
              if (fill != '0) begin
                ctrl.shift_down = 1'b1;
                fill_next       = fill - 1'b1;
                ok_next         = 1'b1;
              end
            end
            sdq_pkg::REQ_POP_BACK: begin
              load_rsp = 1'b1;
              if (fill != '0) begin
                fill_next = fill - 1'b1;
                ok_next   = 1'b1;
              end
            end
            sdq_pkg::REQ_READ_AT, sdq_pkg::REQ_SEARCH: begin
              state_next = sdq_pkg::S_SCAN;
            end
            default: begin
              load_rsp = 1'b1;
            end
          endcase
        end
      end
      sdq_pkg::S_SCAN: begin
        ctrl.scan_en  = 1'b1;
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_cnt == SCAN_LAST) begin
          state_next = sdq_pkg::S_DONE;
        end
      end
      sdq_pkg::S_DONE: begin
        // The last cell now holds the first hit of the whole row.
        if (out_free) begin
          load_rsp   = 1'b1;
          ok_next    = hits[DEPTH-1];
          data_next  = hits[DEPTH-1] ? sdq_pkg::VALUE_W'(hit_words[DEPTH-1]) : '0;
          state_next = sdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sdq_pkg::S_IDLE;
      fill     <= '0;
      scan_cnt <= '0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      scan_cnt <= scan_cnt_next;
    end
  end

  // Hold the lookup operands for the length of the scan.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      read_q <= (sdq_pkg::req_t'(req_type) == sdq_pkg::REQ_READ_AT);
      key    <= new_word;
      pos_q  <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      ok   <= ok_next;
      data <= data_next;
    end
  end

  // Cell row: position i from the front lives in cell i.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w;
    logic [DATA_WIDTH-1:0] next_w;
    logic                  hit_in;
    logic [DATA_WIDTH-1:0] hdata_in;

    if (i == 0) begin : g_first
      assign prev_w   = new_word;
      assign hit_in   = 1'b0;
      assign hdata_in = '0;
    end else begin : g_mid
      assign prev_w   = words[i-1];
      assign hit_in   = hits[i-1];
      assign hdata_in = hit_words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_w = words[i];
    end else begin : g_inner
      assign next_w = words[i+1];
    end

    sdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .FILL_W     (FILL_W),
      .INDEX      (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .fill         (fill),
      .key          (key),
      .pos          (pos_q),
      .new_word     (new_word),
      .prev_word    (prev_w),
      .next_word    (next_w),
      .scan_hit_in  (hit_in),
      .scan_data_in (hdata_in),
      .word         (words[i]),
      .scan_hit     (hits[i]),
      .scan_data    (hit_words[i])
    );
  end

  `SDQ_ASSERT_ALWAYS(a_fill_bound, clk, rst || (fill <= FULL), "fill count above depth")
  `SDQ_ASSERT(a_push_grows, clk, rst, (req_fire && (req_type == sdq_pkg::REQ_PUSH_BACK) && (fill != FULL)) |=> (fill == $past(fill) + 1'b1), "push back did not grow the count")
  `SDQ_ASSERT(a_done_loads, clk, rst, (state == sdq_pkg::S_DONE && out_free) |=> (rsp_valid && state == sdq_pkg::S_IDLE), "finished lookup did not load a result")

endmodule

@@ sim/tb_searchable_deque_unit.sv @@
// Self-checking testbench for the searchable deque: directed corners, then random traffic.
`timescale 1ns / 1ps
module tb_searchable_deque_unit;

  localparam int DEPTH        = sdq_pkg::DEPTH_DEF;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int REQ_W        = sdq_pkg::REQ_W;
  localparam int VALUE_W      = sdq_pkg::VALUE_W;
  localparam int POS_W        = sdq_pkg::POS_W;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 400000;

  // Request codes the block must ignore (answer ok 0, data 0, count unchanged).
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  localparam sdq_pkg::req_t OP_LIST [6] = '{
    sdq_pkg::REQ_PUSH_FRONT, sdq_pkg::REQ_PUSH_BACK, sdq_pkg::REQ_POP_FRONT,
    sdq_pkg::REQ_POP_BACK, sdq_pkg::REQ_READ_AT, sdq_pkg::REQ_SEARCH};

  localparam logic [VALUE_W-1:0] W_MAX_POS  = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] W_MIN_NEG  = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] W_ALL_ONES = 32'hffff_ffff;
  localparam logic [VALUE_W-1:0] W_ZERO     = 32'h0000_0000;
  localparam logic [VALUE_W-1:0] W_ABSENT   = 32'h1234_5678;

  // Traffic mixes for the random part.
  typedef enum int {
    MIX_GROW,
    MIX_DRAIN,
    MIX_ANY
  } mix_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] data;
    logic [CNT_W-1:0]   count;
  } result_t;

  // Shadow copy of the deque plus the queue of results still owed by the block.
  class deque_tracker;
    logic [VALUE_W-1:0] slots [DEPTH];
    int                 head;
    int                 fill;
    int                 errors;
    result_t            awaited_results [$];

    function void note_request(logic [REQ_W-1:0] kind, logic [VALUE_W-1:0] word,
                               logic [POS_W-1:0] pos);
      result_t r;
      r = '0;
      case (kind)
        sdq_pkg::REQ_PUSH_FRONT: if (fill < DEPTH) begin
          head = (head + DEPTH - 1) % DEPTH;
          slots[head] = word;
          fill++;
          r.ok = 1'b1;
        end
        sdq_pkg::REQ_PUSH_BACK: if (fill < DEPTH) begin
          slots[(head + fill) % DEPTH] = word;
          fill++;
          r.ok = 1'b1;
        end
        sdq_pkg::REQ_POP_FRONT: if (fill > 0) begin
          head = (head + 1) % DEPTH;
          fill--;
          r.ok = 1'b1;
        end
        sdq_pkg::REQ_POP_BACK: if (fill > 0) begin
          fill--;
          r.ok = 1'b1;
        end
        sdq_pkg::REQ_READ_AT: if (pos < fill) begin
          r.ok   = 1'b1;
          r.data = slots[(head + pos) % DEPTH];
        end
        sdq_pkg::REQ_SEARCH: for (int i = 0; i < fill; i++) begin
          if (!r.ok && slots[(head + i) % DEPTH] == word) begin
            r.ok   = 1'b1;
            r.data = word;
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(fill);
      awaited_results.push_back(r);
    endfunction

    function void check_response(logic got_ok, logic [VALUE_W-1:0] got_data,
                                 logic [CNT_W-1:0] got_count);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got_ok !== want.ok) begin
        $error("ok: expected %0d actual %0d", want.ok, got_ok);
        errors++;
      end
      if (got_data !== want.data) begin
        $error("data: expected %08h actual %08h", want.data, got_data);
        errors++;
      end
      if (got_count !== want.count) begin
        $error("count: expected %0d actual %0d", want.count, got_count);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function logic [VALUE_W-1:0] word_at(int p);
      return slots[(head + p) % DEPTH];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  logic                      req_valid;
  logic                      req_ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;
  logic                      rsp_valid;
  logic                      rsp_ready;
  logic                      ok;
  logic signed [VALUE_W-1:0] data;
  logic [CNT_W-1:0]          count;

  deque_tracker sb;

  int burst_left  = 1;
  int stall_pct   = 0;
  int stall_left  = 0;
  int cycle_count = 0;

  searchable_deque_unit #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(sdq_pkg::DATA_W_DEF)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_type (req_type),
    .value    (value),
    .position (position),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .ok       (ok),
    .data     (data),
    .count    (count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: hold a stall rate for a random stretch, then pick a new one.
  // A rate of zero gives stretches where every result beat is taken at once.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(40, 400);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    stall_left--;
    rsp_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  // Result monitor: sample at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      sb.check_response(ok, data, count);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return W_MAX_POS;
      1:       return W_MIN_NEG;
      2:       return W_ALL_ONES;
      3:       return W_ZERO;
      default: return $urandom();
    endcase
  endfunction

  // Build one request for the given mix. Searches mostly look for a stored
  // word so hits are common; reads mostly land near the count, at it or below.
  function automatic void pick_request(input mix_t m, output logic [REQ_W-1:0] kind,
                                       output logic [VALUE_W-1:0] word,
                                       output logic [POS_W-1:0] pos);
    int r;
    r = $urandom_range(0, 99);
    case (m)
      MIX_GROW: begin
        if (r < 80) begin
          kind = $urandom_range(0, 1) ? sdq_pkg::REQ_PUSH_FRONT : sdq_pkg::REQ_PUSH_BACK;
        end else if (r < 90) begin
          kind = sdq_pkg::REQ_READ_AT;
        end else begin
          kind = sdq_pkg::REQ_SEARCH;
        end
      end
      MIX_DRAIN: begin
        if (r < 80) begin
          kind = $urandom_range(0, 1) ? sdq_pkg::REQ_POP_FRONT : sdq_pkg::REQ_POP_BACK;
        end else if (r < 90) begin
          kind = sdq_pkg::REQ_READ_AT;
        end else begin
          kind = sdq_pkg::REQ_SEARCH;
        end
      end
      default: begin
        if (r < 6) kind = r[0] ? REQ_SPARE_A : REQ_SPARE_B;
        else       kind = OP_LIST[$urandom_range(0, 5)];
      end
    endcase
    word = pick_word();
    pos  = POS_W'($urandom_range(0, 255));
    if (kind == sdq_pkg::REQ_SEARCH && sb.fill > 0 && $urandom_range(0, 99) < 60) begin
      word = sb.word_at(int'($urandom_range(0, sb.fill - 1)));
    end
    if (kind == sdq_pkg::REQ_READ_AT && $urandom_range(0, 99) < 75) begin
      pos = POS_W'($urandom_range(0, sb.fill));
    end
  endfunction

  // Drive one request beat and hold it until accepted. Between bursts, drop
  // valid for a random gap; a gap of zero keeps valid high into the next beat.
  task automatic issue_request(input logic [REQ_W-1:0] kind,
                               input logic [VALUE_W-1:0] word,
                               input logic [POS_W-1:0] pos);
    int gap;
    req_valid <= 1'b1;
    req_type  <= kind;
    value     <= word;
    position  <= pos;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(kind, word, pos);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every owed result beat has been taken.
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int                 sent;
    int                 len;
    mix_t               m;
    logic [REQ_W-1:0]   kind;
    logic [VALUE_W-1:0] word;
    logic [POS_W-1:0]   pos;

    sent      = 0;
    sb        = new;
    rst       = 1'b1;
    req_valid = 1'b0;
    req_type  = '0;
    value     = '0;
    position  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty store: every pop, read and search must fail; spare codes do nothing.
    issue_request(sdq_pkg::REQ_POP_FRONT, W_ZERO, 8'd0);
    issue_request(sdq_pkg::REQ_POP_BACK, W_ALL_ONES, 8'd255);
    issue_request(sdq_pkg::REQ_READ_AT, W_ZERO, 8'd0);
    issue_request(sdq_pkg::REQ_SEARCH, W_ZERO, 8'd0);
    issue_request(REQ_SPARE_A, W_MAX_POS, 8'd1);
    issue_request(REQ_SPARE_B, W_MIN_NEG, 8'd2);

    // Build [0, min, max, -1] from both ends with the extreme words.
    issue_request(sdq_pkg::REQ_PUSH_BACK, W_MAX_POS, 8'd0);
    issue_request(sdq_pkg::REQ_PUSH_FRONT, W_MIN_NEG, 8'd0);
    issue_request(sdq_pkg::REQ_PUSH_BACK, W_ALL_ONES, 8'd0);
    issue_request(sdq_pkg::REQ_PUSH_FRONT, W_ZERO, 8'd0);

    // Reads in range, at the count and far past it.
    issue_request(sdq_pkg::REQ_READ_AT, W_ZERO, 8'd0);
    issue_request(sdq_pkg::REQ_READ_AT, W_ZERO, 8'd3);
    issue_request(sdq_pkg::REQ_READ_AT, W_ZERO, 8'd4);
    issue_request(sdq_pkg::REQ_READ_AT, W_ZERO, 8'd255);

    // Search for all ones must report a hit, not be confused with a miss.
    issue_request(sdq_pkg::REQ_SEARCH, W_ALL_ONES, 8'd0);
    issue_request(sdq_pkg::REQ_SEARCH, W_MIN_NEG, 8'd0);
    issue_request(sdq_pkg::REQ_SEARCH, W_ABSENT, 8'd0);
    issue_request(REQ_SPARE_B, W_ZERO, 8'd0);

    // Shrink from both ends back to empty.
    issue_request(sdq_pkg::REQ_POP_FRONT, W_ZERO, 8'd0);
    issue_request(sdq_pkg::REQ_POP_BACK, W_ZERO, 8'd0);
    issue_request(sdq_pkg::REQ_READ_AT, W_ZERO, 8'd0);
    issue_request(sdq_pkg::REQ_POP_FRONT, W_ZERO, 8'd0);
    issue_request(sdq_pkg::REQ_POP_BACK, W_ZERO, 8'd0);

    // Fill to capacity, then push into the full store.
    while (sb.fill < DEPTH) begin
      pick_request(MIX_GROW, kind, word, pos);
      issue_request(kind, word, pos);
      sent++;
    end
    repeat (6) begin
      kind = $urandom_range(0, 1) ? sdq_pkg::REQ_PUSH_FRONT : sdq_pkg::REQ_PUSH_BACK;
      issue_request(kind, pick_word(), POS_W'($urandom_range(0, 255)));
      sent++;
    end

    // Hold off the sender until the block has answered everything.
    settle();

    // Drain to empty, then pop the empty store a few times.
    while (sb.fill > 0) begin
      pick_request(MIX_DRAIN, kind, word, pos);
      issue_request(kind, word, pos);
      sent++;
    end
    repeat (3) begin
      kind = $urandom_range(0, 1) ? sdq_pkg::REQ_POP_FRONT : sdq_pkg::REQ_POP_BACK;
      issue_request(kind, pick_word(), POS_W'($urandom_range(0, 255)));
      sent++;
    end

    // Phases of random length, each with its own mix.
    while (sent < RANDOM_ITEMS) begin
      m   = mix_t'($urandom_range(0, 2));
      len = $urandom_range(10, 60);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      repeat (len) begin
        pick_request(m, kind, word, pos);
        issue_request(kind, word, pos);
        sent++;
      end
    end

    // Collect the last results, then allow a lookup's worth of cycles for strays.
    settle();
    repeat (DEPTH + 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
